/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the key matrix debounce RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every clk edge outside reset
`define KMDR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// implication form: ante |-> cons
`define KMDR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

/* rtl/kmdr_pkg.sv */
// ----------------------------------------------------------------------------
// kmdr_pkg
// Shared widths, register codes and chain word types.
// ----------------------------------------------------------------------------
package kmdr_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned KEY_W     = 16;
	localparam int unsigned DEB_W     = 16;
	localparam int unsigned CODE_W    = 8;
	localparam int unsigned COUNT_W   = 3;
	localparam int unsigned MAX_SLOTS = 6;
	localparam int unsigned MAP_W     = 64;

	// register indexes (paddr[4:3])
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_KEYMAP_LO = 2'd1;
	localparam logic [1:0] REG_KEYMAP_HI = 2'd2;

	// scan word walking down the chain
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] now_ms;
		logic [KEY_W-1:0]  raw_keys;
	} scan_t;

	// partial report built up cell by cell
	typedef struct packed {
		logic                               changed;
		logic [COUNT_W-1:0]                 code_count;
		logic [MAX_SLOTS-1:0][CODE_W-1:0]   keycode;
		logic [KEY_W-1:0]                   debounced_keys;
	} acc_t;

endpackage

/* rtl/kmdr_cell.sv */
// ----------------------------------------------------------------------------
// kmdr_cell
// One key: debounce state plus its contribution to the report.
// ----------------------------------------------------------------------------
module kmdr_cell #(
	parameter int unsigned KEY          = 0,
	parameter int unsigned REPORT_SLOTS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [kmdr_pkg::DEB_W-1:0]  hold_off_ms,
	input  logic [kmdr_pkg::CODE_W-1:0] keycode,
	input  kmdr_pkg::scan_t            scan_in,
	input  kmdr_pkg::acc_t             acc_in,
	output kmdr_pkg::scan_t            scan_out,
	output kmdr_pkg::acc_t             acc_out
);
	import kmdr_pkg::*;
	`include "assert_macros.svh"

	logic              pressed_q;
	logic [TIME_W-1:0] change_time_q;
	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic [KEY_W-1:0]  raw_s1;
	acc_t              acc_s1;

	logic [TIME_W-1:0] elapsed;
	logic              flip;
	logic              pressed_next;
	acc_t              acc_next;

	always_comb begin
		elapsed      = scan_in.now_ms - change_time_q;
		flip         = (elapsed > {{(TIME_W-DEB_W){1'b0}}, hold_off_ms})
		               && (scan_in.raw_keys[KEY] != pressed_q);
		pressed_next = flip ? scan_in.raw_keys[KEY] : pressed_q;

		acc_next                     = acc_in;
		acc_next.changed             = acc_in.changed | flip;
		acc_next.debounced_keys[KEY] = pressed_next;
		if (pressed_next && (acc_in.code_count < COUNT_W'(REPORT_SLOTS))) begin
			acc_next.keycode[acc_in.code_count] = keycode;
			acc_next.code_count                 = acc_in.code_count + COUNT_W'(1);
		end
	end

	// key state and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q     <= 1'b0;
			change_time_q <= '0;
			valid_s1      <= 1'b0;
		end else if (en) begin
			valid_s1 <= scan_in.valid;
			if (scan_in.valid && flip) begin
				pressed_q     <= pressed_next;
				change_time_q <= scan_in.now_ms;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			now_s1 <= scan_in.now_ms;
			raw_s1 <= scan_in.raw_keys;
			acc_s1 <= acc_next;
		end
	end

	assign scan_out = '{valid: valid_s1, now_ms: now_s1, raw_keys: raw_s1};
	assign acc_out  = acc_s1;

	`KMDR_ASSERT_IMPL(a_stall_holds_key, !en, ##1 $stable(pressed_q),
		"key state moved during stall")
	`KMDR_ASSERT_IMPL(a_count_in_range, valid_s1,
		acc_s1.code_count <= COUNT_W'(REPORT_SLOTS), "slot count overflow")
	`KMDR_ASSERT_IMPL(a_bitmap_matches_state, valid_s1,
		acc_s1.debounced_keys[KEY] == pressed_q, "reported bit differs from key state")

endmodule

/* rtl/kmdr_out.sv */
// ----------------------------------------------------------------------------
// kmdr_out
// Output register with skid slot; packs the finished report.
// ----------------------------------------------------------------------------
module kmdr_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  kmdr_pkg::acc_t in_acc,
	output logic           advance,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [71:0]    m_tdata,
	output logic           m_tuser
);
	import kmdr_pkg::*;
	`include "assert_macros.svh"

	logic skid_full_q;
	acc_t out_acc_q;
	acc_t skid_acc_q;
	logic take;
	logic arrive;

	assign take    = m_tvalid && m_tready;
	assign advance = !skid_full_q;
	assign arrive  = advance && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid    <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take) begin
				skid_full_q <= 1'b0;
			end
		end else if (!m_tvalid || take) begin
			m_tvalid <= arrive;
		end else if (arrive) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) begin
				out_acc_q <= skid_acc_q;
			end
		end else if (!m_tvalid || take) begin
			out_acc_q <= in_acc;
		end else begin
			skid_acc_q <= in_acc;
		end
	end

	// low to high: code_count, keycode_0..5, debounced_keys, zero pad
	assign m_tdata = {5'd0, out_acc_q.debounced_keys, out_acc_q.keycode[5],
	                  out_acc_q.keycode[4], out_acc_q.keycode[3], out_acc_q.keycode[2],
	                  out_acc_q.keycode[1], out_acc_q.keycode[0], out_acc_q.code_count};
	assign m_tuser = out_acc_q.changed;

	`KMDR_ASSERT_IMPL(a_skid_implies_out, skid_full_q, m_tvalid,
		"skid holds a word while output is empty")

endmodule

/* rtl/key_matrix_debounce_report.sv */
// ----------------------------------------------------------------------------
// key_matrix_debounce_report
// Per-key debounce of a scanned key matrix with a six-key report.
// ----------------------------------------------------------------------------
// Takes one scan word per clock, back to back. Each key of the ROWS x COLS
// matrix owns one cell in a chain; a scan walks the chain one cell per cycle,
// each cell updating its own debounced bit and change time and dropping its
// keycode into the next free report slot. The report is registered in each
// key cell in turn and then in the output register. The output stage has a
// skid slot, so the input keeps flowing while one report waits; s_tready
// drops only when both the output register and the skid slot are full, and
// the whole chain then holds. Registers are to be written through the APB
// port only while no scan is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module key_matrix_debounce_report #(
	parameter int unsigned ROWS         = 3,
	parameter int unsigned COLS         = 3,
	parameter int unsigned REPORT_SLOTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// scan input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [31:0] now_ms, [47:32] raw_keys
	// report output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [2:0] code_count, [10:3] keycode_0, [18:11] keycode_1,
	                               // [26:19] keycode_2, [34:27] keycode_3, [42:35] keycode_4,
	                               // [50:43] keycode_5, [66:51] debounced_keys, [71:67] zero
	output logic        m_tuser,   // [0] report_valid
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import kmdr_pkg::*;

	localparam int unsigned NKEYS = ROWS * COLS;

	// configuration registers
	logic [DEB_W-1:0] hold_off_ms_q;
	logic [MAP_W-1:0] keymap_low_q;
	logic [MAP_W-1:0] keymap_high_q;
	logic [1:0]       reg_idx;
	logic             wr_en;
	logic [2*MAP_W-1:0] keymap;

	// chain
	scan_t scan_c [NKEYS+1];
	acc_t  acc_c  [NKEYS+1];
	logic  advance;

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off_ms_q <= DEB_W'(5);
			keymap_low_q  <= '0;
			keymap_high_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DEBOUNCE:  hold_off_ms_q <= pwdata[DEB_W-1:0];
				REG_KEYMAP_LO: keymap_low_q  <= pwdata;
				REG_KEYMAP_HI: keymap_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE:  prdata = {{(MAP_W-DEB_W){1'b0}}, hold_off_ms_q};
			REG_KEYMAP_LO: prdata = keymap_low_q;
			REG_KEYMAP_HI: prdata = keymap_high_q;
			default:       prdata = '0;
		endcase
	end

	assign keymap = {keymap_high_q, keymap_low_q};

	// ---------------- key cell chain ----------------
	assign s_tready  = advance;
	assign scan_c[0] = '{valid: s_tvalid && advance, now_ms: s_tdata[31:0],
	                     raw_keys: s_tdata[47:32]};
	assign acc_c[0]  = '0;

	for (genvar k = 0; k < NKEYS; k++) begin : g_key
		kmdr_cell #(
			.KEY          (k),
			.REPORT_SLOTS (REPORT_SLOTS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (advance),
			.hold_off_ms (hold_off_ms_q),
			.keycode     (keymap[k*CODE_W +: CODE_W]),
			.scan_in     (scan_c[k]),
			.acc_in      (acc_c[k]),
			.scan_out    (scan_c[k+1]),
			.acc_out     (acc_c[k+1])
		);
	end

	// ---------------- output stage ----------------
	kmdr_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (scan_c[NKEYS].valid),
		.in_acc   (acc_c[NKEYS]),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key matrix debounce and six-key report block.
// ----------------------------------------------------------------------------
// Drives scan words (time stamp + raw key bits) on the input stream and
// programs the debounce time and both keymaps over APB while the block is
// idle. A local debounce predictor tracks each key's debounced bit and last
// change time and builds the expected report for every accepted scan word.
// Reports are compared field by field in arrival order. A short directed
// table runs first, followed by randomized phases with a fresh register setup
// in each. Both stream sides idle and stall at random. One phase holds off
// the receiver long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kmdr_pkg::*;

	localparam int unsigned ROWS            = 3;
	localparam int unsigned COLS            = 3;
	localparam int unsigned SLOTS           = 6;
	localparam int unsigned NKEYS           = ROWS * COLS;
	// one register per key cell plus the output register
	localparam int unsigned LATENCY         = NKEYS + 1;
	localparam int unsigned NUM_PHASES      = 6;
	localparam int unsigned ITEMS_PER_PHASE = 200;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned CYCLE_LIMIT     = 1_000_000;

	// paddr[4:3] = 3 is past the register list; writes there must be dropped
	localparam logic [1:0] REG_NONE = 2'd3;

	// one expected or observed report
	typedef struct packed {
		logic                             report_valid;
		logic [COUNT_W-1:0]               code_count;
		logic [MAX_SLOTS-1:0][CODE_W-1:0] keycode;
		logic [KEY_W-1:0]                 debounced_keys;
	} report_t;

	typedef enum logic {ROW_SCAN, ROW_WRITE} row_kind_e;

	// one row of the directed table
	typedef struct packed {
		row_kind_e         kind;
		logic [1:0]        reg_idx;
		logic [63:0]       value;
		logic [TIME_W-1:0] now_ms;
		logic [KEY_W-1:0]  raw_keys;
		logic              fixed;   // use the typed-in report instead of the predictor
		report_t           want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // [31:0] now_ms, [47:32] raw_keys
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // [2:0] code_count, [50:3] keycode_0..5, [66:51] debounced_keys
	logic        m_tuser;   // [0] report_valid
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	key_matrix_debounce_report #(
		.ROWS(ROWS),
		.COLS(COLS),
		.REPORT_SLOTS(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// ------------------------------------------------------------------------
	// Predictor state: register copies and per-key debounce state
	// ------------------------------------------------------------------------
	logic [DEB_W-1:0]  cfg_debounce;
	logic [MAP_W-1:0]  cfg_map_lo;
	logic [MAP_W-1:0]  cfg_map_hi;
	logic              held_bit [NKEYS];
	logic [TIME_W-1:0] last_change [NKEYS];

	report_t   pending_reports [$];   // expected reports, oldest first
	plan_row_t directed_plan [$];
	int        mismatches;
	int        cycle_count;
	bit        hold_req;              // asks the receiver for one long hold-off
	bit        steady;                // sender sends back to back when set
	report_t   seen_rep;
	report_t   due_rep;

	// ------------------------------------------------------------------------
	// Clock, cycle limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Debounce predictor: one scan in, one report out, state updated in place
	// ------------------------------------------------------------------------
	task automatic debounce_scan(input logic [TIME_W-1:0] now, input logic [KEY_W-1:0] raw,
			output report_t rep);
		logic [TIME_W-1:0] elapsed;
		logic [127:0]      keymap;
		int                slot;
		keymap = {cfg_map_hi, cfg_map_lo};
		rep = '0;
		slot = 0;
		// bits above the matrix never reach a key
		for (int k = 0; k < NKEYS; k++) begin
			// wrapping difference, strictly greater than the debounce time
			elapsed = now - last_change[k];
			if (elapsed > {16'd0, cfg_debounce} && raw[k] != held_bit[k]) begin
				held_bit[k] = raw[k];
				last_change[k] = now;
				rep.report_valid = 1'b1;
			end
			if (held_bit[k]) begin
				rep.debounced_keys[k] = 1'b1;
				// only the first SLOTS pressed keys, row-major, get a slot
				if (slot < SLOTS) begin
					rep.keycode[slot] = keymap[8*k +: 8];
					slot++;
				end
			end
		end
		rep.code_count = slot[COUNT_W-1:0];
	endtask

	// ------------------------------------------------------------------------
	// Directed table builders
	// ------------------------------------------------------------------------
	task automatic add_scan(input logic [TIME_W-1:0] now, input logic [KEY_W-1:0] raw);
		plan_row_t row;
		row = '0;
		row.kind = ROW_SCAN;
		row.now_ms = now;
		row.raw_keys = raw;
		directed_plan.push_back(row);
	endtask

	task automatic add_fixed(input logic [TIME_W-1:0] now, input logic [KEY_W-1:0] raw,
			input logic flag, input logic [COUNT_W-1:0] count,
			input logic [MAX_SLOTS*CODE_W-1:0] codes, input logic [KEY_W-1:0] keys);
		plan_row_t row;
		row = '0;
		row.kind = ROW_SCAN;
		row.now_ms = now;
		row.raw_keys = raw;
		row.fixed = 1'b1;
		row.want.report_valid = flag;
		row.want.code_count = count;
		row.want.keycode = codes;
		row.want.debounced_keys = keys;
		directed_plan.push_back(row);
	endtask

	task automatic add_write(input logic [1:0] idx, input logic [63:0] value);
		plan_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_idx = idx;
		row.value = value;
		directed_plan.push_back(row);
	endtask

	// ------------------------------------------------------------------------
	// Bus tasks
	// ------------------------------------------------------------------------
	// Sender gap: mostly none, some short, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Offers one scan word and records the expected report once it is taken.
	task automatic send_scan(input logic [TIME_W-1:0] now, input logic [KEY_W-1:0] raw,
			input logic fixed, input report_t want);
		int      gap;
		report_t rep;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {raw, now};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		debounce_scan(now, raw, rep);
		if (fixed)
			rep = want;
		pending_reports.push_back(rep);
	endtask

	// Stops offering words and waits until every report is back.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// Setup cycle, access cycle; the register takes the value at the access edge.
	task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DEBOUNCE:  cfg_debounce = value[DEB_W-1:0];
			REG_KEYMAP_LO: cfg_map_lo = value;
			REG_KEYMAP_HI: cfg_map_hi = value;
			default: ;   // outside the register list: dropped
		endcase
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Report checker
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_rep.report_valid = m_tuser;
			seen_rep.code_count = m_tdata[2:0];
			seen_rep.keycode = m_tdata[50:3];
			seen_rep.debounced_keys = m_tdata[66:51];
			if (pending_reports.size() == 0) begin
				$error("report word with nothing expected: tdata %0h tuser %0b",
					m_tdata, m_tuser);
				mismatches++;
			end else begin
				due_rep = pending_reports.pop_front();
				check_field("report_valid", 48'(due_rep.report_valid),
					48'(seen_rep.report_valid));
				check_field("code_count", 48'(due_rep.code_count),
					48'(seen_rep.code_count));
				for (int j = 0; j < MAX_SLOTS; j++)
					check_field($sformatf("keycode_%0d", j), 48'(due_rep.keycode[j]),
						48'(seen_rep.keycode[j]));
				check_field("debounced_keys", 48'(due_rep.debounced_keys),
					48'(seen_rep.debounced_keys));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random ready pattern, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int len;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// long stall: chain and skid slot fill, s_tready must drop
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						m_tready <= 1'b1;
						len = $urandom_range(1, 24);
					end
					6, 7, 8: begin
						m_tready <= 1'b0;
						len = $urandom_range(1, 3);
					end
					default: begin
						m_tready <= 1'b0;
						len = $urandom_range(10, 40);
					end
				endcase
				repeat (len) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [TIME_W-1:0] clock_ms;
		logic [KEY_W-1:0]  raw_now;
		logic [63:0]       wval;
		logic [DEB_W-1:0]  deb_pick;

		// predictor at reset values
		cfg_debounce = 16'd5;
		cfg_map_lo = '0;
		cfg_map_hi = '0;
		for (int k = 0; k < NKEYS; k++) begin
			held_bit[k] = 1'b0;
			last_change[k] = '0;
		end
		mismatches = 0;
		hold_req = 1'b0;
		steady = 1'b0;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// --- directed table ---
		// reset registers: debounce 5, keymaps zero
		// time 0 equals every change time, so nothing may move
		add_fixed(32'h0000_0000, 16'hFFFF, 1'b0, 3'd0, 48'h0, 16'h0000);
		// 6 ms later all nine keys press; bits above the matrix ignored, six slots
		add_fixed(32'h0000_0006, 16'hFFFF, 1'b1, 3'd6, 48'h0, 16'h01FF);
		// release 1 ms later is still in the debounce window
		add_fixed(32'h0000_0007, 16'h0000, 1'b0, 3'd6, 48'h0, 16'h01FF);
		// key k -> code k+1; unused upper keymap bytes all ones
		add_write(REG_KEYMAP_LO, 64'h0807_0605_0403_0201);
		add_write(REG_KEYMAP_HI, 64'hFFFF_FFFF_FFFF_FF09);
		add_fixed(32'h0000_000C, 16'h0000, 1'b1, 3'd0, 48'h0, 16'h0000);
		add_fixed(32'h0000_0014, 16'h01FF, 1'b1, 3'd6, 48'h0605_0403_0201, 16'h01FF);
		add_scan(32'h0000_0015, 16'h0100);
		add_scan(32'h0000_001A, 16'h0100);
		add_scan(32'h0000_001B, 16'hFE00);
		// zero debounce: any later ms may flip, same ms may not
		add_write(REG_DEBOUNCE, 64'h0);
		add_scan(32'h0000_001B, 16'h00AA);
		add_scan(32'h0000_001B, 16'h0055);
		add_scan(32'h0000_001C, 16'h0055);
		// widest debounce: 65535 ms is not enough, 65536 ms is
		add_write(REG_DEBOUNCE, 64'hFFFF);
		add_scan(32'h0001_001B, 16'h0000);
		add_scan(32'h0001_001C, 16'h0000);
		// write past the register list must leave the debounce time alone
		add_write(REG_NONE, 64'h0);
		add_scan(32'h0001_001D, 16'h01FF);
		add_write(REG_DEBOUNCE, 64'h5);
		// timer wrap: 4 ms across zero is held off, 6 ms is not
		add_scan(32'hFFFF_FFFE, 16'h0003);
		add_scan(32'h0000_0002, 16'h0000);
		add_scan(32'h0000_0004, 16'h0000);
		add_scan(32'hFFFF_FFFF, 16'hFFFF);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			case (directed_plan[i].kind)
				ROW_WRITE: begin
					wait_drain();
					apb_write(directed_plan[i].reg_idx, directed_plan[i].value);
				end
				default: begin
					send_scan(directed_plan[i].now_ms, directed_plan[i].raw_keys,
						directed_plan[i].fixed, directed_plan[i].want);
				end
			endcase
		end

		// --- random phases, fresh register setup in each ---
		clock_ms = $urandom;
		raw_now = '0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drain();
			case ($urandom_range(0, 7))
				0:       deb_pick = 16'd0;
				1:       deb_pick = 16'hFFFF;
				2:       deb_pick = DEB_W'($urandom_range(0, 65535));
				default: deb_pick = DEB_W'($urandom_range(1, 12));
			endcase
			// upper pwdata bits are noise; only the low 16 count
			wval = {$urandom, $urandom};
			wval[DEB_W-1:0] = deb_pick;
			apb_write(REG_DEBOUNCE, wval);
			apb_write(REG_KEYMAP_LO, {$urandom, $urandom});
			apb_write(REG_KEYMAP_HI, {$urandom, $urandom});
			if ($urandom_range(0, 1))
				apb_write(REG_NONE, {$urandom, $urandom});
			steady = (ph == 4);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// receiver stalls while scans keep coming
				if (ph == 2 && n == 50)
					hold_req = 1'b1;
				// sender waits until every report is back
				if (ph == 3 && n == 100)
					wait_drain();

				// time mostly creeps forward, scaled to the debounce time
				case ($urandom_range(0, 19))
					0:       clock_ms = $urandom;
					1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * cfg_debounce + 4);
					2:       clock_ms = clock_ms + cfg_debounce + $urandom_range(0, 2);
					default: clock_ms = clock_ms + $urandom_range(0, cfg_debounce / 3 + 2);
				endcase
				// keys are held, bounce one bit, or jump to a new pattern
				case ($urandom_range(0, 9))
					0:       raw_now = KEY_W'($urandom);
					1, 2, 3: raw_now = raw_now ^ (16'd1 << $urandom_range(0, 15));
					4:       raw_now = raw_now ^ 16'($urandom_range(0, 511));
					default: ;
				endcase
				send_scan(clock_ms, raw_now, 1'b0, '0);
			end
		end

		// --- wind down ---
		steady = 1'b0;
		wait_drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
